// File: sv/steq_pkg.sv
package steq_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DATA_W      = 32;

    // stream payload widths
    localparam int IDX_W       = 11;
    localparam int REQ_W       = 2;
    localparam int S_TDATA_W   = 2 * DATA_W;
    localparam int S_TUSER_W   = REQ_W;
    localparam int M_TDATA_W   = 24;

    // request kinds carried in s_tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    // result beat, first field in the highest bits
    typedef struct packed {
        logic             status;
        logic             found;
        logic [IDX_W-1:0] last_index;
        logic [IDX_W-1:0] first_index;
    } result_t;

    // table write shared by both search lanes
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } table_wr_t;

    // search start command
    typedef struct packed {
        logic              start;
        logic              upper;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] key;
    } lane_cmd_t;

    // search completion
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] bound;
    } lane_rsp_t;

endpackage

// File: sv/steq_ram.sv
module steq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/steq_lane.sv
module steq_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  steq_pkg::lane_cmd_t cmd,
    input  steq_pkg::table_wr_t wr,
    output steq_pkg::lane_rsp_t rsp
);

    import steq_pkg::*;

    typedef enum logic [1:0] {
        L_IDLE = 2'b01,
        L_READ = 2'b10
    } lane_state_t;

    lane_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic              upper_reg, upper_next;
    logic              done_reg, done_next;

    logic              rd_en;
    logic [DATA_W-1:0] rd_data;
    logic              go_right;
    logic [CNT_W-1:0]  lo_step;
    logic [CNT_W-1:0]  hi_step;

    // private copy of the table, one probe per cycle
    steq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (mid_next[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // compare the probed entry and narrow the interval
    always_comb
    begin
        if (upper_reg)
        begin
            go_right = !($signed(key_reg) < $signed(rd_data));
        end
        else
        begin
            go_right = $signed(rd_data) < $signed(key_reg);
        end
        lo_step = go_right ? (mid_reg + CNT_W'(1)) : lo_reg;
        hi_step = go_right ? hi_reg : mid_reg;
    end

    // search sequencer
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        upper_next = upper_reg;
        done_next  = 1'b0;
        rd_en      = 1'b0;
        unique case (state_reg)
            L_IDLE:
            begin
                if (cmd.start)
                begin
                    lo_next    = '0;
                    hi_next    = cmd.count;
                    key_next   = cmd.key;
                    upper_next = cmd.upper;
                    if (cmd.count != '0)
                    begin
                        mid_next   = cmd.count >> 1;
                        rd_en      = 1'b1;
                        state_next = L_READ;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            L_READ:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step)
                begin
                    mid_next = lo_step + ((hi_step - lo_step) >> 1);
                    rd_en    = 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // search interval and key
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        upper_reg <= upper_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.bound = lo_reg;

endmodule

// File: sv/sorted_table_equal_range_core.sv
// append, clear and unknown requests go straight to the done state, then the output register
// a query goes through the search state, then the done state, into the output register
// throughput: one request at a time, the next is taken once the result enters the output register
// lower and upper bound run in parallel on two table copies, one memory probe per cycle each
// reset: entry count cleared and output invalid; table contents are not cleared, no clearing pass
module sorted_table_equal_range_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [steq_pkg::S_TDATA_W-1:0]   s_tdata,  // element, key
    input  logic [steq_pkg::S_TUSER_W-1:0]   s_tuser,  // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [steq_pkg::M_TDATA_W-1:0]   m_tdata   // first_index, last_index, found, status
);

    import steq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } core_state_t;

    core_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    result_t          res_reg, res_next;
    logic             lo_done_reg, lo_done_next;
    logic             hi_done_reg, hi_done_next;
    logic             m_valid_reg, m_valid_next;
    result_t          m_data_reg, m_data_next;

    logic              accept;
    logic              full;
    req_t              req;
    logic [DATA_W-1:0] element;
    logic [DATA_W-1:0] key;
    table_wr_t         wr;
    lane_cmd_t         lo_cmd;
    lane_cmd_t         hi_cmd;
    lane_rsp_t         lo_rsp;
    lane_rsp_t         hi_rsp;
    logic              lo_d;
    logic              hi_d;

    // input beat decode
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign req      = req_t'(s_tuser);
    assign element  = s_tdata[DATA_W-1:0];
    assign key      = s_tdata[2*DATA_W-1:DATA_W];
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));

    // append writes both table copies
    assign wr.en   = accept && (req == REQ_APPEND) && !full;
    assign wr.addr = count_reg[ADDR_W-1:0];
    assign wr.data = element;

    // search commands
    assign lo_cmd.start = accept && (req == REQ_QUERY);
    assign lo_cmd.upper = 1'b0;
    assign lo_cmd.count = count_reg;
    assign lo_cmd.key   = key;
    assign hi_cmd.start = accept && (req == REQ_QUERY);
    assign hi_cmd.upper = 1'b1;
    assign hi_cmd.count = count_reg;
    assign hi_cmd.key   = key;

    steq_lane u_lo_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lo_cmd),
        .wr    (wr),
        .rsp   (lo_rsp)
    );

    steq_lane u_hi_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hi_cmd),
        .wr    (wr),
        .rsp   (hi_rsp)
    );

    assign lo_d = lo_done_reg || lo_rsp.done;
    assign hi_d = hi_done_reg || hi_rsp.done;

    // request sequencer and output register
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        lo_done_next = lo_done_reg;
        hi_done_next = hi_done_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                    unique case (req)
                        REQ_APPEND:
                        begin
                            if (full)
                            begin
                                res_next.status = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_QUERY:
                        begin
                            lo_done_next = 1'b0;
                            hi_done_next = 1'b0;
                            state_next   = S_SEARCH;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                lo_done_next = lo_d;
                hi_done_next = hi_d;
                if (lo_d && hi_d)
                begin
                    res_next.first_index = IDX_W'(lo_rsp.bound);
                    res_next.last_index  = IDX_W'(hi_rsp.bound - CNT_W'(1));
                    res_next.found       = (hi_rsp.bound > lo_rsp.bound);
                    res_next.status      = 1'b0;
                    state_next           = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            lo_done_reg <= 1'b0;
            hi_done_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            lo_done_reg <= lo_done_next;
            hi_done_reg <= hi_done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: sv/steq_chk.sv
module steq_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [steq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [steq_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [steq_pkg::M_TDATA_W-1:0] m_tdata
);

    import steq_pkg::*;

    result_t res;

    assign res = result_t'(m_tdata);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one request at a time: no input beat right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in flight");

    // a dropped append carries no search result
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.status |-> !res.found && res.first_index == '0 && res.last_index == '0)
        else $error("dropped append with search fields set");

    // a missed key reports the insertion point and the point before it
    a_miss_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.found && !res.status |->
            (res.last_index == res.first_index - IDX_W'(1)) ||
            (res.first_index == '0 && res.last_index == '0))
        else $error("miss result with inconsistent bounds");

    // a hit has a non-empty index range
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.found |-> !res.status && res.last_index >= res.first_index)
        else $error("hit result with empty range");

endmodule

bind sorted_table_equal_range_core steq_chk u_steq_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb_sorted_table_equal_range_core.sv
`timescale 1ns / 100ps

module tb_sorted_table_equal_range_core;

    import steq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int PHASE_ITEMS = 40;

    // one request beat as queued for the driver
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] element;
        logic [DATA_W-1:0] key;
    } request_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // request stream and result tracking
    request_beat_t request_queue[$];
    request_beat_t next_beat;
    result_t       predicted_results[$];
    result_t       got;
    result_t       want;

    // shadow of the table contents kept by the predictor
    logic signed [DATA_W-1:0] tbl_vals[TABLE_DEPTH];
    int                       entry_total = 0;

    // contents appended so far, as seen by the stimulus side
    logic [DATA_W-1:0] loaded_keys[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase_items = 0;
    int error_count = 0;
    int n_append = 0;
    int n_dropped = 0;
    int n_query = 0;
    int n_hit = 0;
    int n_clear = 0;
    int n_unknown = 0;

    sorted_table_equal_range_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // lower bound when upper is clear, upper bound when set
    function automatic int find_bound(logic signed [DATA_W-1:0] key, bit upper);
        int lo;
        int hi;
        int mid;
        bit go_right;
        lo = 0;
        hi = entry_total;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            go_right = upper ? !(key < tbl_vals[mid]) : (tbl_vals[mid] < key);
            if (go_right)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // update the shadow table and work out the result beat of one request
    function automatic result_t apply_request(logic [REQ_W-1:0] req,
                                              logic signed [DATA_W-1:0] element,
                                              logic signed [DATA_W-1:0] key);
        result_t r;
        int lo;
        int hi;
        int last;
        r = '0;
        case (req)
            REQ_APPEND:
            begin
                n_append++;
                if (entry_total < TABLE_DEPTH)
                begin
                    tbl_vals[entry_total] = element;
                    entry_total++;
                end
                else
                begin
                    r.status = 1'b1;
                    n_dropped++;
                end
            end
            REQ_QUERY:
            begin
                n_query++;
                lo = find_bound(key, 1'b0);
                hi = find_bound(key, 1'b1);
                last = hi - 1;
                r.first_index = lo[IDX_W-1:0];
                r.last_index = last[IDX_W-1:0];
                r.found = (hi > lo);
                if (hi > lo)
                    n_hit++;
            end
            REQ_CLEAR:
            begin
                n_clear++;
                entry_total = 0;
            end
            default:
                n_unknown++;
        endcase
        return r;
    endfunction

    // request driver, predicts each beat as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_results.push_back(apply_request(s_tuser, s_tdata[DATA_W-1:0],
                                                          s_tdata[2*DATA_W-1:DATA_W]));
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_beat.req;
                    s_tdata <= {next_beat.key, next_beat.element};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_val, got_val);
            error_count++;
        end
    endtask

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none got %h",
                             $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    report_field("first_index", want.first_index, got.first_index);
                    report_field("last_index", want.last_index, got.last_index);
                    report_field("found", want.found, got.found);
                    report_field("status", want.status, got.status);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // queue one request and mirror its effect on the loaded contents
    task automatic push_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] element,
                                logic [DATA_W-1:0] key);
        request_beat_t b;
        b.req = req;
        b.element = element;
        b.key = key;
        request_queue.push_back(b);
        if (req == REQ_CLEAR)
            loaded_keys.delete();
        else if (req == REQ_APPEND && loaded_keys.size() < TABLE_DEPTH)
            loaded_keys.push_back(element);
        if (req != REQ_UNKNOWN)
            phase_items++;
    endtask

    // key that mostly hits the table or lands right beside an entry
    function automatic logic [DATA_W-1:0] pick_key();
        int sel;
        logic [DATA_W-1:0] base;
        sel = $urandom_range(9);
        if (loaded_keys.size() == 0 || sel == 8)
            return $urandom();
        base = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
        if (sel <= 4)
            return base;
        if (sel <= 6)
            return base + 1;
        if (sel == 7)
            return base - 1;
        case ($urandom_range(2))
            0: return VAL_MIN;
            1: return VAL_MAX;
            default: return '0;
        endcase
    endfunction

    task automatic push_query();
        push_request(REQ_QUERY, $urandom(), pick_key());
    endtask

    // extremes, every request kind, duplicates, misses, empty and unsorted tables
    task automatic run_directed();
        push_request(REQ_QUERY, '0, '0);
        push_request(REQ_UNKNOWN, '0, '0);
        push_request(REQ_CLEAR, '0, '0);
        push_request(REQ_APPEND, VAL_MIN, '1);
        push_request(REQ_APPEND, -32'sd5, '0);
        push_request(REQ_APPEND, -32'sd5, '1);
        push_request(REQ_APPEND, -32'sd5, '0);
        push_request(REQ_APPEND, 32'sd0, '1);
        push_request(REQ_APPEND, 32'sd7, '0);
        push_request(REQ_APPEND, VAL_MAX, '1);
        push_request(REQ_QUERY, '1, VAL_MIN);
        push_request(REQ_QUERY, '0, -32'sd5);
        push_request(REQ_QUERY, '1, -32'sd6);
        push_request(REQ_QUERY, '0, 32'sd6);
        push_request(REQ_QUERY, '1, VAL_MAX);
        push_request(REQ_QUERY, '0, 32'sd0);
        push_request(REQ_UNKNOWN, '1, '1);
        push_request(REQ_CLEAR, '1, '1);
        push_request(REQ_QUERY, '1, '0);
        push_request(REQ_APPEND, 32'sd5, '0);
        push_request(REQ_APPEND, 32'sd1, '0);
        push_request(REQ_APPEND, 32'sd9, '0);
        push_request(REQ_QUERY, '0, 32'sd1);
        push_request(REQ_QUERY, '0, 32'sd9);
        push_request(REQ_CLEAR, '0, '0);
    endtask

    // one random group: sorted load plus queries, unsorted load, or noise
    task automatic run_batch();
        int kind;
        int n;
        bit narrow;
        longint v;
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            if ($urandom_range(9) != 0)
                push_request(REQ_CLEAR, $urandom(), $urandom());
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 20);
            narrow = $urandom_range(1);
            if (loaded_keys.size() != 0)
                v = $signed(loaded_keys[$]);
            else
            begin
                case ($urandom_range(3))
                    0: v = VAL_MIN;
                    1:
                    begin
                        v = $urandom_range(0, 40);
                        v = v - 20;
                    end
                    default: v = int'($urandom());
                endcase
            end
            for (int i = 0; i < n; i++)
            begin
                // occasional stray request in the middle of a load
                if ($urandom_range(24) == 0)
                begin
                    if ($urandom_range(1))
                        push_query();
                    else
                        push_request(REQ_UNKNOWN, $urandom(), $urandom());
                end
                push_request(REQ_APPEND, v[DATA_W-1:0], $urandom());
                if (narrow)
                    v = v + $urandom_range(0, 2);
                else
                    v = v + ($urandom() >> $urandom_range(4, 31));
                if (v > VAL_MAX)
                    v = VAL_MAX;
            end
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                push_query();
        end
        else if (kind < 90)
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(1))
                    push_request(REQ_APPEND, $urandom(), $urandom());
                else
                begin
                    v = $urandom_range(0, 8);
                    v = v - 4;
                    push_request(REQ_APPEND, v[DATA_W-1:0], $urandom());
                end
            end
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                push_query();
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                push_request(REQ_W'($urandom_range(3)), $urandom(), $urandom());
        end
    endtask

    // load the whole table, overflow it and search at full depth
    task automatic fill_table();
        longint v;
        push_request(REQ_CLEAR, $urandom(), $urandom());
        v = $urandom_range(0, 1000);
        v = v - 3000;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            push_request(REQ_APPEND, v[DATA_W-1:0], $urandom());
            v = v + $urandom_range(0, 3);
        end
        for (int i = 0; i < 3; i++)
            push_request(REQ_APPEND, $urandom(), $urandom());
        push_request(REQ_QUERY, $urandom(), loaded_keys[0]);
        push_request(REQ_QUERY, $urandom(), loaded_keys[TABLE_DEPTH-1]);
        push_request(REQ_QUERY, $urandom(), VAL_MAX);
        push_request(REQ_QUERY, $urandom(), VAL_MIN);
        for (int i = 0; i < 20; i++)
            push_query();
    endtask

    // sample on the falling edge so the driver's edge updates have settled
    task automatic wait_quiet();
        while (request_queue.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    // main sequence: reset, then one stimulus phase per idling mode
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            phase_items = 0;
            if (phase == 0)
                run_directed();
            while (phase_items < PHASE_ITEMS)
                run_batch();
            if (phase == 3)
                fill_table();
            wait_quiet();
        end
        repeat (32) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            $display("%0t: %0d result beats never arrived", $time, predicted_results.size());
            error_count++;
        end
        $display("run covered %0d appends (%0d dropped on a full table), %0d clears, %0d unknown",
                 n_append, n_dropped, n_clear, n_unknown);
        $display("and %0d searches, %0d of them hits, across four idling modes", n_query, n_hit);
        if (error_count == 0)
            $display("sorted_table_equal_range_core verification clean");
        else
            $display("sorted_table_equal_range_core verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("sorted_table_equal_range_core verification failed");
        $finish;
    end

endmodule

// File: sim.f
sv/steq_pkg.sv
sv/steq_ram.sv
sv/steq_lane.sv
sv/sorted_table_equal_range_core.sv
sv/steq_chk.sv
tb/tb_sorted_table_equal_range_core.sv
